[sv/sha_pkg.sv]
`timescale 1ns / 1ps

package sha_pkg;

  // Byte offsets inside a 64-byte block that the padding logic watches.
  localparam logic [5:0] BlockLastFill = 6'd63;
  localparam logic [5:0] LengthFill    = 6'd56;

  // First padding byte after the message.
  localparam logic [7:0] PadByte = 8'h80;

  // Digest word positions and schedule window depth.
  localparam logic [2:0] LastWordIdx = 3'd7;
  localparam int unsigned NumWords   = 8;
  localparam int unsigned WinDepth   = 16;

  // Initial chaining value of SHA-256.
  localparam logic [31:0] InitHash [NumWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Requests from the byte sequencer to the round unit.
  typedef struct packed {
    logic       load;   // shift one message byte into the schedule window
    logic       start;  // begin compressing the window into the chain
    logic       init;   // return the chain to the initial hash value
    logic [7:0] data;   // byte to shift in
  } core_ctl_t;

  // Round constants, one per round.
  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[sv/sha_core.sv]
`timescale 1ns / 1ps

module sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha_pkg::core_ctl_t ctl_i,
  input  logic [2:0]         rd_idx_i,
  output logic               busy_o,
  output logic [31:0]        digest_o
);
  import sha_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_ADD
  } core_state_e;

  core_state_e state_q;
  logic [5:0]  rnd_q;
  logic [31:0] chain_q [NumWords];
  logic [31:0] vars_q  [NumWords];
  logic [31:0] win_q   [WinDepth];

  logic [31:0] w_new;
  logic [31:0] w_cur;
  logic [31:0] t1;
  logic [31:0] t2;

  // Schedule expansion and one compression round.
  always_comb begin
    w_new = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
    w_cur = (rnd_q[5:4] == 2'd0) ? win_q[0] : w_new;
    t1 = vars_q[7] + big_sigma1(vars_q[4])
       + ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]))
       + round_k(rnd_q) + w_cur;
    t2 = big_sigma0(vars_q[0])
       + ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));
  end

  assign busy_o   = (state_q != C_IDLE);
  assign digest_o = chain_q[rd_idx_i];

  // Sequencer, round counter and chaining value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      rnd_q   <= '0;
      chain_q <= InitHash;
    end else begin
      case (state_q)
        C_IDLE: begin
          if (ctl_i.init) begin
            chain_q <= InitHash;
          end
          if (ctl_i.start) begin
            rnd_q   <= '0;
            state_q <= C_RUN;
          end
        end
        C_RUN: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == BlockLastFill) begin
            state_q <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < NumWords; i++) begin
            chain_q[i] <= chain_q[i] + vars_q[i];
          end
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  // Working variables and schedule window; both are written before use.
  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE) begin
      if (ctl_i.load) begin
        // The window acts as one 512-bit shift register, big-endian.
        for (int i = 0; i < WinDepth - 1; i++) begin
          win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
        end
        win_q[WinDepth-1] <= {win_q[WinDepth-1][23:0], ctl_i.data};
      end
      if (ctl_i.start) begin
        vars_q <= chain_q;
      end
    end else if (state_q == C_RUN) begin
      for (int i = 0; i < WinDepth - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WinDepth-1] <= w_cur;
      vars_q[7] <= vars_q[6];
      vars_q[6] <= vars_q[5];
      vars_q[5] <= vars_q[4];
      vars_q[4] <= vars_q[3] + t1;
      vars_q[3] <= vars_q[2];
      vars_q[2] <= vars_q[1];
      vars_q[1] <= vars_q[0];
      vars_q[0] <= t1 + t2;
    end
  end

endmodule

[sv/sha256_stream_hash.sv]
`timescale 1ns / 1ps

// SHA-256 of a byte stream, one byte per input request. A request with tuser
// set carries a message byte; tlast ends the message, and a request with tuser
// clear and tlast set ends it without a byte. Every 64th byte starts a
// compression in the shared round unit, which runs one round per cycle through
// 64 rounds and a chain update. Input is taken again in the cycle after the
// compression ends. At the end of a message the padding bytes go through the
// same byte path, one per cycle, and each padded block is followed by the same
// compression wait; the first digest word is loaded once the last padded
// block is compressed. Then the eight digest words leave the output register,
// word 0 (most significant) first, one per accepted output request, and the
// hash restarts from the initial value for the next message. Input is not
// taken while a compression, the padding or the digest readout is in progress.
module sha256_stream_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_axis_tlast    // last_word
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMP,
    S_PAD,
    S_PCOMP,
    S_OUT
  } top_state_e;

  top_state_e  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] total_q, total_d;
  logic [63:0] len_q, len_d;
  logic        first_q, first_d;
  logic        lenph_q, lenph_d;
  logic [2:0]  ocnt_q, ocnt_d;
  logic        mvalid_q, mvalid_d;
  logic [31:0] mdata_q, mdata_d;
  logic [2:0]  midx_q, midx_d;
  logic        mlast_q, mlast_d;

  core_ctl_t   ctl;
  logic        core_busy;
  logic [31:0] digest;
  logic        out_free;

  sha_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .rd_idx_i (ocnt_q),
    .busy_o   (core_busy),
    .digest_o (digest)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {5'd0, midx_q, mdata_q};
  assign m_axis_tlast  = mlast_q;
  assign out_free      = !mvalid_q || m_axis_tready;

  // Byte gathering, padding and digest readout sequencer.
  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    total_d  = total_q;
    len_d    = len_q;
    first_d  = first_q;
    lenph_d  = lenph_q;
    ocnt_d   = ocnt_q;
    mvalid_d = mvalid_q;
    mdata_d  = mdata_q;
    midx_d   = midx_q;
    mlast_d  = mlast_q;
    ctl      = '0;

    if (mvalid_q && m_axis_tready) begin
      mvalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            ctl.load  = 1'b1;
            ctl.data  = s_axis_tdata;
            ctl.start = (fill_q == BlockLastFill);
            fill_d    = fill_q + 6'd1;
            total_d   = total_q + 61'd1;
          end
          if (s_axis_tlast) begin
            len_d   = {total_d, 3'b000};
            first_d = 1'b1;
            lenph_d = 1'b0;
            state_d = ctl.start ? S_PCOMP : S_PAD;
          end else if (ctl.start) begin
            state_d = S_COMP;
          end
        end
      end
      S_COMP: begin
        if (!core_busy) begin
          state_d = S_IDLE;
        end
      end
      S_PAD: begin
        // Marker byte first, then zeros up to the length field, then the length.
        ctl.load = 1'b1;
        fill_d   = fill_q + 6'd1;
        if (first_q) begin
          ctl.data = PadByte;
          first_d  = 1'b0;
        end else if (lenph_q || (fill_q == LengthFill)) begin
          ctl.data = len_q[63:56];
          len_d    = {len_q[55:0], 8'h00};
          lenph_d  = 1'b1;
        end else begin
          ctl.data = 8'h00;
        end
        if (fill_q == BlockLastFill) begin
          ctl.start = 1'b1;
          state_d   = S_PCOMP;
        end
      end
      S_PCOMP: begin
        if (!core_busy) begin
          state_d = (lenph_q && (fill_q == 6'd0)) ? S_OUT : S_PAD;
        end
      end
      S_OUT: begin
        if (out_free) begin
          mvalid_d = 1'b1;
          mdata_d  = digest;
          midx_d   = ocnt_q;
          mlast_d  = (ocnt_q == LastWordIdx);
          ocnt_d   = ocnt_q + 3'd1;
          if (ocnt_q == LastWordIdx) begin
            ctl.init = 1'b1;
            total_d  = '0;
            fill_d   = '0;
            state_d  = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      total_q  <= '0;
      first_q  <= 1'b0;
      lenph_q  <= 1'b0;
      ocnt_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      total_q  <= total_d;
      first_q  <= first_d;
      lenph_q  <= lenph_d;
      ocnt_q   <= ocnt_d;
      mvalid_q <= mvalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    mdata_q <= mdata_d;
    midx_q  <= midx_d;
    mlast_q <= mlast_d;
  end

endmodule

[sv/sha_checker.sv]
`timescale 1ns / 1ps

module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import sha_pkg::*;

  // The final digest word carries the last position, and only it does.
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == LastWordIdx)))
    else $error("tlast does not match the word position");

  // No input is taken while the digest readout is still in progress.
  a_no_input_midway: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("input ready during digest readout");

  // Digest words follow one another in order.
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (!m_axis_tvalid || (m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)))
    else $error("digest word out of order");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind sha256_stream_hash sha_checker u_sha_checker (.*);

[sim/sha256_stream_hash_tb.sv]
`timescale 1ns / 1ps

module sha256_stream_hash_tb;

  import sha_pkg::*;

  // One byte request on the input stream.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } byte_req_t;

  // One digest word on the output stream.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  localparam logic [7:0] PadMark  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  localparam logic [31:0] ShaIv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Message lengths around the padding and block boundaries.
  localparam int EdgeLen [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  byte_req_t    req_q [$];
  digest_word_t digest_q [$];
  int           mismatches = 0;

  // Software copy of the hash state.
  logic [31:0] chain [8];
  logic [31:0] win [16];
  logic [60:0] byte_cnt;
  logic [5:0]  fill;

  // Sender burst and gap counters, receiver stall pattern.
  int          burst_left = 0;
  int          gap_left = 0;
  logic [31:0] ready_pat = '1;
  logic [4:0]  ready_pos = '0;

  sha256_stream_hash i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_restart();
    for (int i = 0; i < 8; i++) chain[i] = ShaIv[i];
    for (int i = 0; i < 16; i++) win[i] = '0;
    byte_cnt = '0;
    fill = '0;
  endfunction

  // Run the 64 rounds over the window and fold the result into the chain.
  function automatic void hash_block();
    logic [31:0] v [8];
    logic [31:0] x2, x15, t1, t2;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      if (r >= 16) begin
        x2  = win[(r - 2) & 15];
        x15 = win[(r - 15) & 15];
        win[r & 15] = (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10)) + win[(r - 7) & 15]
                    + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + win[r & 15];
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + win[r & 15];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endfunction

  // Place one byte big-endian in the window; a full block is compressed.
  function automatic void absorb(input logic [7:0] b);
    int sh;
    sh = 24 - 8 * int'(fill[1:0]);
    win[fill[5:2]][sh +: 8] = b;
    fill = fill + 6'd1;
    if (fill == 6'd0) hash_block();
  endfunction

  // Update the state for one accepted request and queue any digest words.
  function automatic void hash_step(input byte_req_t req);
    logic [63:0] bit_len;
    digest_word_t dw;
    if (req.has_byte) begin
      absorb(req.data);
      byte_cnt = byte_cnt + 61'd1;
    end
    if (!req.last) return;
    bit_len = {byte_cnt, 3'b000};
    absorb(PadMark);
    while (fill != LenStart) absorb(8'h00);
    for (int i = 0; i < 8; i++) absorb(bit_len[63 - 8 * i -: 8]);
    for (int i = 0; i < NumWords; i++) begin
      dw.word = chain[i];
      dw.idx  = 3'(i);
      dw.last = (dw.idx == LastWordIdx);
      digest_q.push_back(dw);
    end
    hash_restart();
  endfunction

  function automatic void add_req(input logic [7:0] d, input logic hb, input logic lst);
    byte_req_t r;
    r.data = d;
    r.has_byte = hb;
    r.last = lst;
    req_q.push_back(r);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Queue one message with some idle requests mixed in; returns the
  // number of requests that carry a byte or end the message.
  function automatic int add_message(input int len);
    int n;
    logic on_byte;
    n = 0;
    on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) add_req(8'($urandom), 1'b0, 1'b0);
      add_req(pick_byte(), 1'b1, on_byte && (i == len - 1));
      n++;
    end
    if (!on_byte) begin
      add_req(8'($urandom), 1'b0, 1'b1);
      n++;
    end
    return n;
  endfunction

  // Input driver: bursts of requests separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tuser  <= 1'b0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) hash_step(req_q.pop_front());
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= req_q[0].data;
          s_axis_tuser  <= req_q[0].has_byte;
          s_axis_tlast  <= req_q[0].last;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left = 0;
              3, 4, 5: gap_left = $urandom_range(1, 4);
              6:       gap_left = $urandom_range(5, 20);
              default: gap_left = $urandom_range(40, 120);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output ready: a 32-bit pattern reloaded with a random shape.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (ready_pos == 5'd0) begin
        case ($urandom_range(0, 3))
          0:       ready_pat = '1;
          1:       ready_pat = $urandom;
          2:       ready_pat = 32'h0000ffff;
          default: ready_pat = 32'h55555555;
        endcase
      end
      m_axis_tready <= ready_pat[ready_pos];
      ready_pos = ready_pos + 5'd1;
    end
  end

  // Output monitor: each word must match the oldest expected digest word.
  always @(posedge clk_i) begin
    digest_word_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.word = m_axis_tdata[31:0];
      got.idx  = m_axis_tdata[34:32];
      got.last = m_axis_tlast;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h idx %0d last %b", got.word, got.idx, got.last);
      end else begin
        want = digest_q.pop_front();
        if (got.word !== want.word || got.idx !== want.idx || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                     want.word, want.idx, want.last, got.word, got.idx, got.last);
        end
      end
    end
  end

  initial begin
    int len;
    hash_restart();

    // Directed part: idle request, empty message, short messages, edge bytes.
    add_req(8'hff, 1'b0, 1'b0);
    add_req(8'h00, 1'b0, 1'b1);
    add_req(8'h61, 1'b1, 1'b0);
    add_req(8'h62, 1'b1, 1'b0);
    add_req(8'h63, 1'b1, 1'b1);
    add_req(8'h00, 1'b1, 1'b1);
    add_req(8'hff, 1'b1, 1'b1);
    add_req(8'hff, 1'b1, 1'b0);
    add_req(8'h00, 1'b1, 1'b0);
    add_req(8'h80, 1'b1, 1'b0);
    add_req(8'haa, 1'b0, 1'b0);
    add_req(8'h55, 1'b0, 1'b1);
    add_req(8'hff, 1'b0, 1'b1);
    add_req(8'h7f, 1'b1, 1'b0);
    add_req(8'h01, 1'b1, 1'b0);
    add_req(8'h00, 1'b0, 1'b1);

    // Random messages, many of them near the padding boundaries.
    while (req_q.size() < 270) begin
      case ($urandom_range(0, 5))
        0, 1:    len = $urandom_range(0, 8);
        2:       len = $urandom_range(9, 54);
        3:       len = EdgeLen[$urandom_range(0, 7)];
        4:       len = $urandom_range(110, 130);
        default: len = $urandom_range(1, 3);
      endcase
      void'(add_message(len));
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || s_axis_tvalid || digest_q.size() != 0) @(negedge clk_i);
    repeat (300) @(posedge clk_i);

    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
